// ----- design/qbwd_pkg.sv -----
// Shared types and constants for the encoded-word payload decoder.
package qbwd_pkg;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END_OK  = 2'd1;
  localparam logic [1:0] KIND_END_ERR = 2'd2;

  localparam logic MODE_Q = 1'b0;
  localparam logic MODE_B = 1'b1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QMARK = 8'h3f;
  localparam logic [7:0] CHAR_EQ    = 8'h3d;
  localparam logic [7:0] CHAR_UNDER = 8'h5f;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [15:0] COUNT_MAX = 16'hffff;

  // classified input byte, front to back
  typedef struct packed {
    logic       mode;
    logic       term;
    logic       crlf;
    logic       eq;
    logic       under;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       b64_ok;
    logic [5:0] b64_val;
    logic [7:0] data;
  } class_t;

  // one result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] run_count;
  } result_t;

endpackage

// ----- design/qbwd_fifo.sv -----
// Small register-based FIFO with a count; push and pop may share a cycle.
module qbwd_fifo
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2   // at least 2
  )
  (
    input  logic             clk,
    input  logic             rst,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
  );

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] storage [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = storage[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      storage[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/qbwd_front.sv -----
// Front end: mode register and per-byte character classification.
module qbwd_front
  import qbwd_pkg::*;
  (
    input  logic       clk,
    input  logic       rst,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic [7:0] in_byte,
    output class_t     cls
  );

  logic mode;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [6:0] b64_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41;
      return {1'b1, d[5:0]};
    end
    if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'h47;
      return {1'b1, d[5:0]};
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'h04;
      return {1'b1, d[5:0]};
    end
    if (c == 8'h2b) return {1'b1, 6'd62};
    if (c == 8'h2f) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_Q;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  always_comb begin
    logic [4:0] h;
    logic [6:0] b;
    h = hex_decode(in_byte);
    b = b64_decode(in_byte);
    cls.mode    = mode;
    cls.term    = (in_byte == CHAR_NUL) || (in_byte == CHAR_QMARK);
    cls.crlf    = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
    cls.eq      = (in_byte == CHAR_EQ);
    cls.under   = (in_byte == CHAR_UNDER);
    cls.hex_ok  = h[4];
    cls.hex_val = h[3:0];
    cls.b64_ok  = b[6];
    cls.b64_val = b[5:0];
    cls.data    = in_byte;
  end

endmodule

// ----- design/qbwd_back.sv -----
// Back end: escape / base64 state, run counter and result generation.
module qbwd_back
  import qbwd_pkg::*;
  (
    input  logic    clk,
    input  logic    rst,
    input  logic    in_valid,
    input  class_t  in_cls,
    output logic    in_pop,
    input  logic    out_full,
    output logic    out_push,
    output result_t out_res
  );

  localparam logic [1:0] ESC_NORMAL = 2'd0;
  localparam logic [1:0] ESC_EQ     = 2'd1;
  localparam logic [1:0] ESC_HEX    = 2'd2;

  logic [1:0]  escape_phase, escape_phase_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [11:0] bit_accumulator, bit_accumulator_next;
  logic [3:0]  bits_held, bits_held_next;
  logic        skipping, skipping_next;
  logic [15:0] byte_counter, byte_counter_next;

  logic       take;
  logic       do_data;
  logic [7:0] data_val;
  logic       do_end;
  logic [1:0] end_kind;
  logic       do_clear;
  logic [3:0] held_sum;

  // one beat per cycle whenever a classified byte is waiting and the result queue has room
  assign take   = in_valid && !out_full;
  assign in_pop = take;

  always_comb begin
    escape_phase_next    = escape_phase;
    high_nibble_next     = high_nibble;
    bit_accumulator_next = bit_accumulator;
    bits_held_next       = bits_held;
    skipping_next        = skipping;
    byte_counter_next    = byte_counter;
    do_data  = 1'b0;
    data_val = 8'h00;
    do_end   = 1'b0;
    end_kind = KIND_END_OK;
    do_clear = 1'b0;
    held_sum = bits_held + 4'd6;

    if (take) begin
      if (skipping) begin
        if (in_cls.term) begin
          skipping_next = 1'b0;
          do_clear      = 1'b1;
        end
      end else if (in_cls.mode == MODE_Q) begin
        unique case (escape_phase)
          ESC_EQ: begin
            if (in_cls.crlf) begin
              escape_phase_next = ESC_NORMAL;    // soft line break
            end else if (in_cls.hex_ok) begin
              high_nibble_next  = in_cls.hex_val;
              escape_phase_next = ESC_HEX;
            end else begin
              do_end        = 1'b1;
              end_kind      = KIND_END_ERR;
              skipping_next = !in_cls.term;
            end
          end
          ESC_HEX: begin
            if (in_cls.hex_ok) begin
              escape_phase_next = ESC_NORMAL;
              do_data           = 1'b1;
              data_val          = {high_nibble, in_cls.hex_val};
            end else begin
              do_end        = 1'b1;
              end_kind      = KIND_END_ERR;
              skipping_next = !in_cls.term;
            end
          end
          default: begin
            escape_phase_next = ESC_NORMAL;
            if (in_cls.term) begin
              do_end = 1'b1;
            end else if (in_cls.eq) begin
              escape_phase_next = ESC_EQ;
            end else if (in_cls.under) begin
              do_data  = 1'b1;
              data_val = CHAR_SPACE;
            end else begin
              do_data  = 1'b1;
              data_val = in_cls.data;
            end
          end
        endcase
      end else begin
        if (in_cls.term) begin
          do_end = 1'b1;
        end else if (in_cls.b64_ok) begin
          bit_accumulator_next = {bit_accumulator[5:0], in_cls.b64_val};
          if (held_sum >= 4'd8) begin
            bits_held_next = held_sum - 4'd8;
            do_data        = 1'b1;
            // leftover count is 0, 2 or 4
            case (bits_held_next)
              4'd2:    data_val = bit_accumulator_next[9:2];
              4'd4:    data_val = bit_accumulator_next[11:4];
              default: data_val = bit_accumulator_next[7:0];
            endcase
          end else begin
            bits_held_next = held_sum;
          end
        end
      end
    end

    if (do_data && byte_counter != COUNT_MAX) begin
      byte_counter_next = byte_counter + 1'b1;
    end
    if (do_end || do_clear) begin
      escape_phase_next    = ESC_NORMAL;
      high_nibble_next     = 4'h0;
      bit_accumulator_next = 12'h000;
      bits_held_next       = 4'h0;
      byte_counter_next    = 16'h0000;
    end

    out_push          = do_data || do_end;
    out_res.kind      = do_end ? end_kind : KIND_DATA;
    out_res.out_byte  = do_end ? 8'h00 : data_val;
    out_res.run_count = do_end ? byte_counter : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase    <= ESC_NORMAL;
      high_nibble     <= 4'h0;
      bit_accumulator <= 12'h000;
      bits_held       <= 4'h0;
      skipping        <= 1'b0;
      byte_counter    <= 16'h0000;
    end else begin
      escape_phase    <= escape_phase_next;
      high_nibble     <= high_nibble_next;
      bit_accumulator <= bit_accumulator_next;
      bits_held       <= bits_held_next;
      skipping        <= skipping_next;
      byte_counter    <= byte_counter_next;
    end
  end

endmodule

// ----- design/qp_base64_word_decoder.sv -----
// Q / base64 encoded-word payload decoder, one byte per cycle while neither queue is full.
// A pushed byte is classified combinationally and written into the
//   classified-byte queue; the back end then updates its state and writes
//   any result into the result queue, whose head drives the result ports.
// The back-end update sets the rate and stalls while the result queue is full.
// Reset (synchronous, rst high): both queues empty, mode = Q, decoder state
//   and run counter cleared.
module qp_base64_word_decoder
  import qbwd_pkg::*;
  #(
    parameter int MID_DEPTH = 2,  // classified-byte queue, at least 2
    parameter int OUT_DEPTH = 2   // result queue, at least 2
  )
  (
    input  logic        clk,
    input  logic        rst,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [15:0] run_count
  );

  class_t  front_cls;
  logic [$bits(class_t)-1:0]  mid_rdata;
  logic    mid_empty;
  logic    back_pop;
  logic    out_full;
  logic    back_push;
  result_t back_res;
  logic [$bits(result_t)-1:0] out_rdata;
  result_t head;

  qbwd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_byte),
    .cls       (front_cls)
  );

  qbwd_fifo #(
    .WIDTH ($bits(class_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cls),
    .full  (full),
    .pop   (back_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  qbwd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!mid_empty),
    .in_cls   (class_t'(mid_rdata)),
    .in_pop   (back_pop),
    .out_full (out_full),
    .out_push (back_push),
    .out_res  (back_res)
  );

  qbwd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .wdata (back_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign head      = result_t'(out_rdata);
  assign kind      = head.kind;
  assign out_byte  = head.out_byte;
  assign run_count = head.run_count;

endmodule
